FILE: hw/rtl/lcube_pkg.sv
// ----------------------------------------------------------------------------
// LED cube scan driver package
// Shared sizes, pin level layout, scan phases and request kinds.
// ----------------------------------------------------------------------------
package lcube_pkg;

	localparam int COLS    = 8;
	localparam int ROWS    = 8;
	localparam int LAYERS  = 32;

	localparam int COL_X_W   = 3;
	localparam int ROW_Y_W   = 3;
	localparam int LAYER_Z_W = 5;
	localparam int RGB_W     = 3;
	localparam int SEL_W     = 4;

	localparam int COL_W   = $clog2(COLS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int LAYER_W = $clog2(LAYERS);
	localparam int ADDR_W  = 1 + LAYER_W + ROW_W + COL_W;
	localparam int DEPTH   = 1 << ADDR_W;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [RGB_W-1:0]  rgb_t;

	typedef struct packed {
		logic             high_n;
		logic             low_n;
		logic [SEL_W-1:0] sel;
		logic             oe;
		logic             latch;
		logic             clk;
		logic             data;
	} pins_t;

	localparam pins_t PINS_RESET = '{
		high_n: 1'b0, low_n: 1'b1, sel: '0, oe: 1'b1, latch: 1'b0, clk: 1'b0, data: 1'b0
	};

	typedef enum logic [4:0] {
		PH_SETUP   = 5'b00001,
		PH_CLOCK   = 5'b00010,
		PH_BLANK   = 5'b00100,
		PH_LATCH   = 5'b01000,
		PH_RELEASE = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_SETUP,
		OP_CLOCK,
		OP_BLANK,
		OP_LATCH,
		OP_RELEASE
	} op_t;

	localparam logic [1:0] SLOT_LAST = 2'd2;

	function automatic logic [1:0] colour_of(input logic [1:0] slot);
		logic [1:0] c;
		case (slot)
			2'd0: c = 2'd1;
			2'd1: c = 2'd2;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/lcube_req_if.sv
// ----------------------------------------------------------------------------
// LED cube request channel
// Voxel writes and scan ticks with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcube_req_if import lcube_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic                 buffer;
	logic [COL_X_W-1:0]   col_x;
	logic [ROW_Y_W-1:0]   row_y;
	logic [LAYER_Z_W-1:0] layer_z;
	logic [RGB_W-1:0]     rgb;

	modport source (output valid, func, buffer, col_x, row_y, layer_z, rgb, input ready);
	modport sink (input valid, func, buffer, col_x, row_y, layer_z, rgb, output ready);
endinterface

FILE: hw/rtl/lcube_res_if.sv
// ----------------------------------------------------------------------------
// LED cube result channel
// Pin levels after each request, with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcube_res_if import lcube_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             serial_data;
	logic             shift_clock;
	logic             latch_load;
	logic             output_disable;
	logic [SEL_W-1:0] layer_select;
	logic             low_mux_enable_n;
	logic             high_mux_enable_n;
	logic             frame_end;

	modport source (output valid, serial_data, shift_clock, latch_load, output_disable,
		layer_select, low_mux_enable_n, high_mux_enable_n, frame_end, input ready);
	modport sink (input valid, serial_data, shift_clock, latch_load, output_disable,
		layer_select, low_mux_enable_n, high_mux_enable_n, frame_end, output ready);
endinterface

FILE: hw/rtl/led_cube_layer_scan_driver_unit.sv
// ----------------------------------------------------------------------------
// LED cube layer scan driver
// Double-buffered voxel store and bit-banged shift register scan sequencer.
// ----------------------------------------------------------------------------
// Each request on req is either a voxel write (func 0) or a scan tick
// (func 1), and each one produces exactly one result on res with the pin
// levels after that request. A voxel write repeats the current pin levels.
// The scan shifts 3*ROWS*COLS bits per layer, two ticks per bit, and closes
// each layer with blank, latch and release ticks; frame_end marks the
// release tick of the last layer.
// A request accepted at an edge reads or writes the voxel memory at that
// edge and loads the stage-one registers; its result then moves into the
// result register once that is free and shows on res. One request is
// taken per cycle while res is drained. Each request uses the memory for
// at most one access: a voxel write writes, a setup tick reads, other
// ticks use none. After reset, a clearing pass zeroes all DEPTH (4096)
// entries one per cycle; req.ready stays low meanwhile, but cfg writes
// are taken. When res stalls, the result register and one request in
// flight hold, and req.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module led_cube_layer_scan_driver_unit import lcube_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lcube_req_if.sink req,
	lcube_res_if.source res,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	rgb_t mem [DEPTH];

	logic               clr_busy_q;
	addr_t              clr_addr_q;
	logic               disp_q;
	phase_t             phase_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [1:0]         slot_q;
	logic [LAYER_W-1:0] layer_q;

	logic               s1_v_q;
	op_t                op_s1;
	logic [1:0]         colour_s1;
	logic [LAYER_W-1:0] layer_s1;
	logic               fend_s1;
	rgb_t               rd_s1;

	logic               out_v_q;
	pins_t              pins_q;
	logic               fend_q;

	logic               accept;
	logic               s1_adv;
	logic               scan;
	logic               in_range;
	logic               mem_we;
	addr_t              mem_waddr;
	rgb_t               mem_wdata;
	logic               mem_re;
	addr_t              mem_raddr;
	op_t                op_nxt;
	phase_t             phase_nxt;
	logic [COL_W-1:0]   col_nxt;
	logic [ROW_W-1:0]   row_nxt;
	logic [1:0]         slot_nxt;
	logic [LAYER_W-1:0] layer_nxt;
	logic               fend_nxt;
	pins_t              pins_nxt;

	assign s1_adv    = s1_v_q && (!out_v_q || res.ready);
	assign req.ready = !clr_busy_q && (!s1_v_q || s1_adv);
	assign accept    = req.valid && req.ready;
	assign scan      = req.func;
	assign in_range  = (int'(req.col_x) < COLS) && (int'(req.row_y) < ROWS)
		&& (int'(req.layer_z) < LAYERS);

	always_comb begin
		op_nxt    = OP_SETUP;
		phase_nxt = PH_CLOCK;
		col_nxt   = col_q;
		row_nxt   = row_q;
		slot_nxt  = slot_q;
		layer_nxt = layer_q;
		fend_nxt  = 1'b0;
		case (phase_q)
			PH_CLOCK: begin
				op_nxt    = OP_CLOCK;
				phase_nxt = PH_SETUP;
				col_nxt   = col_q + 1'b1;
				if (col_q == COL_W'(COLS - 1)) begin
					col_nxt = '0;
					row_nxt = row_q + 1'b1;
					if (row_q == ROW_W'(ROWS - 1)) begin
						row_nxt  = '0;
						slot_nxt = slot_q + 1'b1;
						if (slot_q == SLOT_LAST) begin
							slot_nxt  = '0;
							phase_nxt = PH_BLANK;
						end
					end
				end
			end
			PH_BLANK: begin
				op_nxt    = OP_BLANK;
				phase_nxt = PH_LATCH;
			end
			PH_LATCH: begin
				op_nxt    = OP_LATCH;
				phase_nxt = PH_RELEASE;
			end
			PH_RELEASE: begin
				op_nxt    = OP_RELEASE;
				phase_nxt = PH_SETUP;
				if (layer_q == LAYER_W'(LAYERS - 1)) begin
					fend_nxt  = 1'b1;
					layer_nxt = '0;
				end else begin
					layer_nxt = layer_q + 1'b1;
				end
			end
			default: begin
				op_nxt    = OP_SETUP;
				phase_nxt = PH_CLOCK;
			end
		endcase
		if (!scan) begin
			op_nxt = OP_WRITE;
		end
	end

	assign mem_we    = clr_busy_q || (accept && !scan && in_range);
	assign mem_waddr = clr_busy_q ? clr_addr_q
		: {req.buffer, LAYER_W'(req.layer_z), ROW_W'(req.row_y), COL_W'(req.col_x)};
	assign mem_wdata = clr_busy_q ? '0 : req.rgb;
	assign mem_re    = accept && (op_nxt == OP_SETUP);
	assign mem_raddr = {disp_q, layer_q, row_q, col_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q <= 1'b0;
		end else if (cfg_we) begin
			disp_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SETUP;
			col_q   <= '0;
			row_q   <= '0;
			slot_q  <= '0;
			layer_q <= '0;
		end else if (accept && scan) begin
			phase_q <= phase_nxt;
			col_q   <= col_nxt;
			row_q   <= row_nxt;
			slot_q  <= slot_nxt;
			layer_q <= layer_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op_nxt;
			colour_s1 <= colour_of(slot_q);
			layer_s1  <= layer_q;
			fend_s1   <= scan && fend_nxt;
		end
	end

	always_comb begin
		pins_nxt = pins_q;
		case (op_s1)
			OP_SETUP: begin
				pins_nxt.clk  = 1'b0;
				pins_nxt.data = rd_s1[colour_s1];
			end
			OP_CLOCK: begin
				pins_nxt.clk = 1'b1;
			end
			OP_BLANK: begin
				pins_nxt.clk    = 1'b0;
				pins_nxt.oe     = 1'b1;
				pins_nxt.sel    = layer_s1[SEL_W-1:0];
				pins_nxt.high_n = layer_s1[SEL_W];
				pins_nxt.low_n  = !layer_s1[SEL_W];
			end
			OP_LATCH: begin
				pins_nxt.latch = 1'b1;
			end
			OP_RELEASE: begin
				pins_nxt.latch = 1'b0;
				pins_nxt.oe    = 1'b0;
			end
			default: begin
				pins_nxt = pins_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			pins_q  <= PINS_RESET;
			fend_q  <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
			pins_q  <= pins_nxt;
			fend_q  <= fend_s1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign res.valid             = out_v_q;
	assign res.serial_data       = pins_q.data;
	assign res.shift_clock       = pins_q.clk;
	assign res.latch_load        = pins_q.latch;
	assign res.output_disable    = pins_q.oe;
	assign res.layer_select      = pins_q.sel;
	assign res.low_mux_enable_n  = pins_q.low_n;
	assign res.high_mux_enable_n = pins_q.high_n;
	assign res.frame_end         = fend_q;

endmodule

FILE: hw/rtl/lcube_chk.sv
// ----------------------------------------------------------------------------
// LED cube scan driver checker
// Port-level properties of the pin sequence, bound to the top level.
// ----------------------------------------------------------------------------
module lcube_chk import lcube_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input logic             shift_clock,
	input logic             latch_load,
	input logic             output_disable,
	input logic [SEL_W-1:0] layer_select,
	input logic             low_mux_enable_n,
	input logic             high_mux_enable_n,
	input logic             frame_end
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(frame_end)
		&& $stable(shift_clock) && $stable(latch_load))
		else $error("result changed while stalled");

	a_clk_latch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(shift_clock && latch_load))
		else $error("shift clock and latch high together");

	a_mux_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> low_mux_enable_n != high_mux_enable_n)
		else $error("multiplexer enables not complementary");

	a_latch_blank: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && latch_load |-> output_disable)
		else $error("latch raised while the display is enabled");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_end |-> !output_disable && !latch_load
		&& high_mux_enable_n && layer_select == '1)
		else $error("frame end outside the last layer release");

endmodule

bind led_cube_layer_scan_driver_unit lcube_chk u_lcube_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.shift_clock       (res.shift_clock),
	.latch_load        (res.latch_load),
	.output_disable    (res.output_disable),
	.layer_select      (res.layer_select),
	.low_mux_enable_n  (res.low_mux_enable_n),
	.high_mux_enable_n (res.high_mux_enable_n),
	.frame_end         (res.frame_end)
);

FILE: tb/tb_led_cube_layer_scan_driver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED cube layer scan driver testbench
// A short table of directed requests is followed by mixed random requests on
// both display buffers and by a scan sweep that switches the displayed buffer
// part way. Every result is checked against its typed pin levels from the
// table or a cycle-free model of the pin sequence and the double-buffered
// voxel store. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_led_cube_layer_scan_driver_unit;
	import lcube_pkg::*;

	localparam logic FN_WRITE = 1'b0;
	localparam logic FN_TICK = 1'b1;
	localparam logic TYPED = 1'b1;
	localparam logic PREDICTED = 1'b0;

	localparam int BITS_PER_LAYER = 3 * ROWS * COLS;
	localparam logic [5:0] COLOUR_SEQ = {2'd0, 2'd2, 2'd1};

	localparam int DIR_N = 24;
	localparam int MIX_N = 600;
	localparam int SWEEP_N = 400;
	localparam int IDLE_PCT = 37;
	localparam int CALM_LO = 300;
	localparam int CALM_HI = 600;
	localparam int HOLD_AT = 1000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;
	localparam int CLK_HALF = 4;
	localparam longint TIMEOUT_NS = 4_000_000;

	typedef struct packed {
		logic                 func;
		logic                 buffer;
		logic [COL_X_W-1:0]   col_x;
		logic [ROW_Y_W-1:0]   row_y;
		logic [LAYER_Z_W-1:0] layer_z;
		logic [RGB_W-1:0]     rgb;
	} voxel_req_t;

	typedef struct packed {
		pins_t pins;
		logic  frame_end;
	} pin_state_t;

	typedef struct packed {
		logic                 func;
		logic                 buffer;
		logic [COL_X_W-1:0]   col_x;
		logic [ROW_Y_W-1:0]   row_y;
		logic [LAYER_Z_W-1:0] layer_z;
		logic [RGB_W-1:0]     rgb;
		logic                 typed;
		logic                 data;
		logic                 clk;
		logic                 latch;
		logic                 oe;
		logic [SEL_W-1:0]     sel;
		logic                 low_n;
		logic                 high_n;
		logic                 fend;
	} dir_row_t;

	// Columns: request fields, then whether the pins are typed in, then
	// data, clock, latch, output disable, select, low and high enables, frame end.
	dir_row_t dir_tab [DIR_N] = '{
		'{FN_WRITE, 0, 0, 0,  0, 7, TYPED,     0, 0, 0, 1, 0, 1, 0, 0},
		'{FN_WRITE, 1, 7, 7, 31, 7, TYPED,     0, 0, 0, 1, 0, 1, 0, 0},
		'{FN_WRITE, 0, 7, 7, 31, 0, TYPED,     0, 0, 0, 1, 0, 1, 0, 0},
		'{FN_WRITE, 0, 1, 0,  0, 2, TYPED,     0, 0, 0, 1, 0, 1, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, TYPED,     1, 0, 0, 1, 0, 1, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, TYPED,     1, 1, 0, 1, 0, 1, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, TYPED,     1, 0, 0, 1, 0, 1, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, TYPED,     1, 1, 0, 1, 0, 1, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, TYPED,     0, 0, 0, 1, 0, 1, 0, 0},
		'{FN_WRITE, 0, 3, 0,  0, 6, TYPED,     0, 0, 0, 1, 0, 1, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, TYPED,     0, 1, 0, 1, 0, 1, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, TYPED,     1, 0, 0, 1, 0, 1, 0, 0},
		'{FN_WRITE, 1, 4, 0,  0, 7, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0},
		'{FN_WRITE, 0, 5, 3, 16, 5, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0},
		'{FN_WRITE, 0, 2, 5,  9, 4, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0},
		'{FN_WRITE, 1, 6, 2,  0, 1, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0},
		'{FN_WRITE, 0, 0, 0,  0, 0, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0},
		'{FN_TICK,  0, 0, 0,  0, 0, PREDICTED, 0, 0, 0, 0, 0, 0, 0, 0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	lcube_req_if req_ch ();
	lcube_res_if res_ch ();

	led_cube_layer_scan_driver_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	rgb_t        voxel_mem [DEPTH];
	int unsigned scan_lyr;
	int unsigned bit_idx;
	phase_t      scan_ph;
	pins_t       pin_lv;
	logic        disp_buf;

	pin_state_t pending_pins [$];
	int issued = 0;
	int results_seen = 0;
	int fail_count = 0;
	int n_writes = 0;
	int n_ticks = 0;
	int frames_done = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always #(CLK_HALF) clk = ~clk;

	function automatic int unsigned vox_addr(input logic b, input int unsigned x,
		input int unsigned y, input int unsigned z);
		return ((b * LAYERS + z) * ROWS + y) * COLS + x;
	endfunction

	function automatic pin_state_t advance_scan(input voxel_req_t r);
		pin_state_t o;
		int unsigned slot;
		int unsigned rem;
		logic [1:0] colour;
		logic [4:0] k;
		o.frame_end = 1'b0;
		if (r.func == FN_WRITE) begin
			n_writes++;
			if (r.col_x < COLS && r.row_y < ROWS && r.layer_z < LAYERS)
				voxel_mem[vox_addr(r.buffer, r.col_x, r.row_y, r.layer_z)] = r.rgb;
		end else begin
			n_ticks++;
			case (scan_ph)
				PH_CLOCK: begin
					pin_lv.clk = 1'b1;
					bit_idx++;
					scan_ph = (bit_idx >= BITS_PER_LAYER) ? PH_BLANK : PH_SETUP;
				end
				PH_BLANK: begin
					k = scan_lyr[4:0];
					pin_lv.clk = 1'b0;
					pin_lv.oe = 1'b1;
					pin_lv.sel = k[3:0];
					pin_lv.high_n = k[4];
					pin_lv.low_n = ~k[4];
					scan_ph = PH_LATCH;
				end
				PH_LATCH: begin
					pin_lv.latch = 1'b1;
					scan_ph = PH_RELEASE;
				end
				PH_RELEASE: begin
					pin_lv.latch = 1'b0;
					pin_lv.oe = 1'b0;
					if (scan_lyr + 1 >= LAYERS) begin
						o.frame_end = 1'b1;
						frames_done++;
						scan_lyr = 0;
					end else begin
						scan_lyr++;
					end
					bit_idx = 0;
					scan_ph = PH_SETUP;
				end
				default: begin
					if (bit_idx >= BITS_PER_LAYER)
						bit_idx = 0;
					slot = bit_idx / (ROWS * COLS);
					rem = bit_idx % (ROWS * COLS);
					colour = COLOUR_SEQ[2 * (slot % 3) +: 2];
					pin_lv.clk = 1'b0;
					pin_lv.data = voxel_mem[vox_addr(disp_buf, rem % COLS, rem / COLS,
						scan_lyr % LAYERS)][colour];
					scan_ph = PH_CLOCK;
				end
			endcase
		end
		o.pins = pin_lv;
		return o;
	endfunction

	function automatic voxel_req_t rand_req(input int write_pct, input bit aim);
		voxel_req_t r;
		r.func = ($urandom_range(99) < write_pct) ? FN_WRITE : FN_TICK;
		r.buffer = 1'($urandom_range(1));
		r.col_x = COL_X_W'($urandom_range(COLS - 1));
		r.row_y = ROW_Y_W'($urandom_range(ROWS - 1));
		r.layer_z = LAYER_Z_W'($urandom_range(LAYERS - 1));
		r.rgb = RGB_W'($urandom_range(7));
		if (aim) begin
			r.buffer = disp_buf;
			r.layer_z = LAYER_Z_W'(scan_lyr);
		end
		return r;
	endfunction

	task automatic flag(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("ERROR: %s", msg);
	endtask

	task automatic check_pin(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got)
			flag($sformatf("result %0d: %s expected %0d, got %0d",
				results_seen, name, want, got));
	endtask

	task automatic issue(input voxel_req_t r, input logic typed, input pin_state_t typed_pins);
		pin_state_t got;
		while (!(issued >= CALM_LO && issued < CALM_HI) && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= r.func;
		req_ch.buffer <= r.buffer;
		req_ch.col_x <= r.col_x;
		req_ch.row_y <= r.row_y;
		req_ch.layer_z <= r.layer_z;
		req_ch.rgb <= r.rgb;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		got = advance_scan(r);
		pending_pins.push_back(typed ? typed_pins : got);
		issued++;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_pins.size() != 0) @(posedge clk);
	endtask

	task automatic set_display(input logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		disp_buf = v;
	endtask

	always @(posedge clk) begin : res_side
		pin_state_t want;
		if (res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (pending_pins.size() == 0) begin
				flag($sformatf("result %0d arrived with no request pending", results_seen));
			end else begin
				want = pending_pins.pop_front();
				check_pin("serial_data", want.pins.data, res_ch.serial_data);
				check_pin("shift_clock", want.pins.clk, res_ch.shift_clock);
				check_pin("latch_load", want.pins.latch, res_ch.latch_load);
				check_pin("output_disable", want.pins.oe, res_ch.output_disable);
				check_pin("layer_select", want.pins.sel, res_ch.layer_select);
				check_pin("low_mux_enable_n", want.pins.low_n, res_ch.low_mux_enable_n);
				check_pin("high_mux_enable_n", want.pins.high_n, res_ch.high_mux_enable_n);
				check_pin("frame_end", want.frame_end, res_ch.frame_end);
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
			res_ch.ready <= 1'b1;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("ERROR: timeout with %0d results still pending", pending_pins.size());
		$display("led_cube_layer_scan_driver_unit verification failed");
		$finish;
	end

	initial begin : stimulus
		dir_row_t row;
		voxel_req_t r;
		pin_state_t tp;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_WRITE;
		req_ch.buffer = 1'b0;
		req_ch.col_x = '0;
		req_ch.row_y = '0;
		req_ch.layer_z = '0;
		req_ch.rgb = '0;
		res_ch.ready = 1'b0;
		for (int i = 0; i < DEPTH; i++)
			voxel_mem[i] = '0;
		scan_lyr = 0;
		bit_idx = 0;
		scan_ph = PH_SETUP;
		pin_lv = PINS_RESET;
		disp_buf = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		set_display(1'b0);

		for (int i = 0; i < DIR_N; i++) begin
			row = dir_tab[i];
			r = '{row.func, row.buffer, row.col_x, row.row_y, row.layer_z, row.rgb};
			tp.pins = '{high_n: row.high_n, low_n: row.low_n, sel: row.sel, oe: row.oe,
				latch: row.latch, clk: row.clk, data: row.data};
			tp.frame_end = row.fend;
			issue(r, row.typed, tp);
		end

		for (int i = 0; i < MIX_N; i++)
			issue(rand_req(45, $urandom_range(3) == 0), PREDICTED, tp);
		drain();
		set_display(1'b1);
		for (int i = 0; i < MIX_N; i++)
			issue(rand_req(45, $urandom_range(3) == 0), PREDICTED, tp);
		drain();
		set_display(1'b0);

		// The sweep is mostly ticks and switches the displayed buffer half way.
		for (int i = 0; i < SWEEP_N; i++) begin
			if (i == SWEEP_N / 2) begin
				drain();
				set_display(1'b1);
			end
			issue(rand_req(10, $urandom_range(1) == 1), PREDICTED, tp);
		end

		drain();
		repeat (8) @(posedge clk);
		if (pending_pins.size() != 0)
			flag($sformatf("%0d results never arrived", pending_pins.size()));
		$display("Run covered %0d requests: %0d voxel writes and %0d scan ticks.",
			issued, n_writes, n_ticks);
		$display("The scan crossed %0d frame end(s) and read out both display buffers.",
			frames_done);
		if (fail_count == 0) begin
			$display("led_cube_layer_scan_driver_unit verification clean");
		end else begin
			$display("led_cube_layer_scan_driver_unit verification failed");
		end
		$finish;
	end

endmodule
